// ===== src/telemetry_frame_capture_core_defines.svh =====
// Assertion macros shared by the capture core.
`ifndef TELEMETRY_FRAME_CAPTURE_CORE_DEFINES_SVH
`define TELEMETRY_FRAME_CAPTURE_CORE_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define TFC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off during reset.
`define TFC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/tfc_pkg.sv =====
package tfc_pkg;

  localparam int BUF_DEPTH_DEF = 64;
  localparam logic [7:0] FLAG_BYTE = 8'h7E;

  localparam logic [1:0] REQ_BYTE    = 2'd0;
  localparam logic [1:0] REQ_RELEASE = 2'd1;
  localparam logic [1:0] REQ_RESYNC  = 2'd2;

  localparam logic MODE_CAPTURE   = 1'b0;
  localparam logic MODE_DELIMITED = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_START = 2'd1,
    ST_FRAME = 2'd2
  } cap_state_t;

  typedef struct packed {
    logic       store_valid;
    logic [5:0] store_index;
    logic [7:0] store_byte;
    logic       frame_start;
    logic       frame_done;
    logic       frame_ready;
    logic [5:0] byte_count;
  } tfc_res_t;

endpackage

// ===== src/tfc_step.sv =====
module tfc_step #(
  parameter int BUF_DEPTH = tfc_pkg::BUF_DEPTH_DEF,
  localparam int IDX_W = $clog2(BUF_DEPTH)
) (
  input  logic                mode,
  input  tfc_pkg::cap_state_t state,
  input  logic [IDX_W-1:0]    idx,
  input  logic                ready,
  input  logic [1:0]          req,
  input  logic [7:0]          data,
  input  logic                err,
  output tfc_pkg::cap_state_t state_nxt,
  output logic [IDX_W-1:0]    idx_nxt,
  output logic                ready_nxt,
  output tfc_pkg::tfc_res_t   res
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BUF_DEPTH - 1);

  logic [IDX_W-1:0] idx_adv;
  logic [IDX_W-1:0] st_idx;
  logic             is_flag;
  logic [IDX_W+5:0] st_idx_ext;
  logic [IDX_W+5:0] cnt_ext;

  assign idx_adv = (idx < LAST_IDX) ? idx + IDX_W'(1) : idx;
  assign is_flag = (data == tfc_pkg::FLAG_BYTE);

  always_comb begin
    state_nxt       = state;
    idx_nxt         = idx;
    ready_nxt       = ready;
    st_idx          = '0;
    res.store_valid = 1'b0;
    res.store_byte  = '0;
    res.frame_start = 1'b0;
    res.frame_done  = 1'b0;
    unique case (req)
      tfc_pkg::REQ_RELEASE: begin
        ready_nxt = 1'b0;
      end
      tfc_pkg::REQ_RESYNC: begin
        if (mode == tfc_pkg::MODE_CAPTURE) begin
          state_nxt = tfc_pkg::ST_IDLE;
          idx_nxt   = '0;
          ready_nxt = 1'b0;
        end
      end
      tfc_pkg::REQ_BYTE: begin
        priority if (err) begin
          state_nxt = tfc_pkg::ST_IDLE;
          idx_nxt   = '0;
          ready_nxt = 1'b0;
        end else if (mode == tfc_pkg::MODE_CAPTURE) begin
          priority if (state == tfc_pkg::ST_FRAME) begin
            res.store_valid = 1'b1;
            st_idx          = idx;
            res.store_byte  = data;
            idx_nxt         = idx_adv;
          end else if (is_flag) begin
            res.store_valid = 1'b1;
            res.store_byte  = data;
            idx_nxt         = IDX_W'(1);
            state_nxt       = tfc_pkg::ST_FRAME;
            res.frame_start = 1'b1;
          end else begin
          end
        end else if (!ready) begin
          priority if (state == tfc_pkg::ST_START) begin
            if (!is_flag) begin
              res.store_valid = 1'b1;
              st_idx          = idx;
              res.store_byte  = data;
              idx_nxt         = idx_adv;
              state_nxt       = tfc_pkg::ST_FRAME;
            end
          end else if (state == tfc_pkg::ST_FRAME) begin
            res.store_valid = 1'b1;
            st_idx          = idx;
            res.store_byte  = data;
            idx_nxt         = idx_adv;
            if (is_flag) begin
              ready_nxt      = 1'b1;
              state_nxt      = tfc_pkg::ST_IDLE;
              res.frame_done = 1'b1;
            end
          end else if (is_flag) begin
            res.store_valid = 1'b1;
            res.store_byte  = data;
            idx_nxt         = IDX_W'(1);
            state_nxt       = tfc_pkg::ST_START;
          end else begin
          end
        end else begin
        end
      end
      default: begin
      end
    endcase
    st_idx_ext      = {6'd0, st_idx};
    cnt_ext         = {6'd0, idx_nxt};
    res.store_index = st_idx_ext[5:0];
    res.frame_ready = ready_nxt;
    res.byte_count  = cnt_ext[5:0];
  end

endmodule

// ===== src/telemetry_frame_capture_core.sv =====
// Telemetry frame capture core.
// Input stream: one word per received UART byte, release or resync request.
//   in_tuser carries the request type and the line error flag, in_tdata the byte.
// Output stream: one result word per input word, describing the buffer write
//   (if any), the frame start/done pulses, frame-ready flag and byte count.
// cfg_valid/cfg_data write the capture mode (0 capture, 1 delimited); cfg_ready
//   is always high and any write returns the frame state to idle.
// Latency: the result appears on out_* the cycle after its input is taken.
// Throughput: one word per cycle while in_tready is high; the frame state is
//   computed combinationally between the input handshake and the output register.
// Stall: while out_tvalid is high and out_tready is low, in_tready drops and
//   the held result stays unchanged. in_tready is also low while cfg_valid is
//   high, so a mode write never lands on an input word.
// Reset (rst_n low, synchronous): mode capture, state idle, index zero,
//   frame-ready clear, no result pending.
`include "telemetry_frame_capture_core_defines.svh"

module telemetry_frame_capture_core #(
  parameter int BUF_DEPTH = tfc_pkg::BUF_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic [2:0]  in_tuser,   // [1:0] req_type, [2] line_error
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [5:0] store_index, [13:6] store_byte,
                                  // [14] frame_start, [15] frame_done,
                                  // [16] frame_ready, [22:17] byte_count, [23] 0
  output logic        out_tuser   // [0] store_valid
);

  localparam int IDX_W = $clog2(BUF_DEPTH);

  logic                mode_r;
  tfc_pkg::cap_state_t state_r, state_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic                ready_r, ready_nxt;
  logic                out_valid_r;
  tfc_pkg::tfc_res_t   res, res_r;
  logic                in_acc;

  assign cfg_ready = 1'b1;
  assign in_tready = (!out_valid_r || out_tready) && !cfg_valid;
  assign in_acc    = in_tvalid && in_tready;

  tfc_step #(
    .BUF_DEPTH(BUF_DEPTH)
  ) u_step (
    .mode      (mode_r),
    .state     (state_r),
    .idx       (idx_r),
    .ready     (ready_r),
    .req       (in_tuser[1:0]),
    .data      (in_tdata),
    .err       (in_tuser[2]),
    .state_nxt (state_nxt),
    .idx_nxt   (idx_nxt),
    .ready_nxt (ready_nxt),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= tfc_pkg::MODE_CAPTURE;
      state_r     <= tfc_pkg::ST_IDLE;
      idx_r       <= '0;
      ready_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        mode_r  <= cfg_data;
        state_r <= tfc_pkg::ST_IDLE;
        idx_r   <= '0;
        ready_r <= 1'b0;
      end else if (in_acc) begin
        state_r <= state_nxt;
        idx_r   <= idx_nxt;
        ready_r <= ready_nxt;
      end
      if (in_acc) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = res_r.store_valid;
  assign out_tdata  = {1'b0, res_r.byte_count, res_r.frame_ready, res_r.frame_done,
                       res_r.frame_start, res_r.store_byte, res_r.store_index};

  `TFC_ASSERT_NOW(a_start_delim, clk, rst_n, state_r == tfc_pkg::ST_START,
    mode_r == tfc_pkg::MODE_DELIMITED, "start state outside delimited mode")
  `TFC_ASSERT_NOW(a_idx_bound, clk, rst_n, 1'b1,
    idx_r <= IDX_W'(BUF_DEPTH - 1), "write index past last buffer entry")
  `TFC_ASSERT_NOW(a_done_flag, clk, rst_n, out_valid_r && res_r.frame_done,
    res_r.store_valid && res_r.store_byte == tfc_pkg::FLAG_BYTE && res_r.frame_ready,
    "frame done without stored closing flag")
  `TFC_ASSERT_NEXT(a_ready_hold, clk, rst_n,
    in_acc && !cfg_valid && ready_r && in_tuser[1:0] == tfc_pkg::REQ_BYTE && !in_tuser[2]
      && mode_r == tfc_pkg::MODE_DELIMITED,
    !res_r.store_valid && ready_r, "byte stored while frame ready")

endmodule
